[rtl/sar_pkg.sv]
// Shared types, codes and sizes of the sparse axis reduce accumulator.
package sar_pkg;

  localparam int NUM_COORDS    = 4;
  localparam int MAX_RANK      = 4;
  localparam int COORD_BITS    = 12;
  localparam int DIM_BITS      = 13;
  localparam int IN_VALUE_BITS = 32;
  localparam int INDEX_BITS    = 12;
  localparam int FUNC_BITS     = 2;
  localparam int STATUS_BITS   = 2;
  localparam int RANK_BITS     = 3;
  localparam int AXIS_BITS     = 2;
  localparam int STEP_BITS     = 2;
  localparam int ADDR_BITS     = 5;
  localparam int DATA_BITS     = 32;

  localparam int DEF_OUT_DEPTH  = 4096;
  localparam int DEF_VALUE_BITS = 32;

  // Item kinds; the unused code behaves as a plain read.
  localparam logic [FUNC_BITS-1:0] FUNC_ACCUM     = 2'd0;
  localparam logic [FUNC_BITS-1:0] FUNC_READ      = 2'd1;
  localparam logic [FUNC_BITS-1:0] FUNC_READ_ZERO = 2'd2;

  localparam logic [STATUS_BITS-1:0] STATUS_OK     = 2'd0;
  localparam logic [STATUS_BITS-1:0] STATUS_BAD    = 2'd1;
  localparam logic [STATUS_BITS-1:0] STATUS_BEYOND = 2'd2;

  // Register indexes.
  localparam logic [2:0] REG_RANK  = 3'd0;
  localparam logic [2:0] REG_AXIS  = 3'd1;
  localparam logic [2:0] REG_DIM_0 = 3'd2;
  localparam logic [2:0] REG_DIM_1 = 3'd3;
  localparam logic [2:0] REG_DIM_2 = 3'd4;
  localparam logic [2:0] REG_DIM_3 = 3'd5;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LIN,
    ST_ADDR,
    ST_RMW
  } sar_state_t;

  typedef struct packed {
    logic [RANK_BITS-1:0]                    rank;
    logic [AXIS_BITS-1:0]                    reduce_axis;
    logic [NUM_COORDS-1:0][DIM_BITS-1:0]     dim_size;
  } sar_cfg_t;

  typedef struct packed {
    logic load;
    logic step;
    logic addr;
    logic commit;
    logic clear;
  } sar_cmd_t;

  typedef struct packed {
    logic new_accum;
    logic step_last;
    logic clear_done;
    logic out_free;
  } sar_stat_t;

endpackage

[rtl/sparse_axis_reduce_accumulator_top.sv]
// Accumulate requests pass through the four-step linearizer (one dimension a
// cycle) and then the single-port read-modify-write; reads skip the linearizer.
// A request is taken only when idle, so the next one waits for the last commit.
// A finished result waits in the output register while the next request is taken.
// Reset (synchronous, active high) restores the register defaults and starts a
// clearing pass over the whole accumulator memory, during which no request is taken.
module sparse_axis_reduce_accumulator_top #(
  parameter int OUT_DEPTH  = sar_pkg::DEF_OUT_DEPTH,
  parameter int VALUE_BITS = sar_pkg::DEF_VALUE_BITS
) (
  input  logic                                      clk,
  input  logic                                      rst,
  // configuration port
  input  logic                                      psel,
  input  logic                                      penable,
  input  logic                                      pwrite,
  input  logic [sar_pkg::ADDR_BITS-1:0]             paddr,
  input  logic [sar_pkg::DATA_BITS-1:0]             pwdata,
  output logic [sar_pkg::DATA_BITS-1:0]             prdata,
  output logic                                      pready,
  // request channel
  input  logic                                      in_valid,
  output logic                                      in_stall,
  input  logic [sar_pkg::FUNC_BITS-1:0]             func,
  input  logic [sar_pkg::COORD_BITS-1:0]            coord_0,
  input  logic [sar_pkg::COORD_BITS-1:0]            coord_1,
  input  logic [sar_pkg::COORD_BITS-1:0]            coord_2,
  input  logic [sar_pkg::COORD_BITS-1:0]            coord_3,
  input  logic signed [sar_pkg::IN_VALUE_BITS-1:0]  nonzero_value,
  input  logic [sar_pkg::INDEX_BITS-1:0]            read_index,
  // result channel
  output logic                                      out_valid,
  input  logic                                      out_stall,
  output logic signed [sar_pkg::IN_VALUE_BITS-1:0]  entry_value,
  output logic [sar_pkg::INDEX_BITS-1:0]            linear_index,
  output logic [sar_pkg::STATUS_BITS-1:0]           status
);

  sar_pkg::sar_cfg_t  cfg;
  sar_pkg::sar_cmd_t  cmd;
  sar_pkg::sar_stat_t stat;

  logic       cfg_we;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_we  = psel && penable && pwrite && pready;

  // Register file: writes beyond the last register drop silently
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rank        <= sar_pkg::RANK_BITS'(2);
      cfg.reduce_axis <= '0;
      for (int i = 0; i < sar_pkg::NUM_COORDS; i++) begin
        cfg.dim_size[i] <= sar_pkg::DIM_BITS'(1);
      end
    end else if (cfg_we) begin
      case (reg_idx)
        sar_pkg::REG_RANK:  cfg.rank        <= pwdata[sar_pkg::RANK_BITS-1:0];
        sar_pkg::REG_AXIS:  cfg.reduce_axis <= pwdata[sar_pkg::AXIS_BITS-1:0];
        sar_pkg::REG_DIM_0: cfg.dim_size[0] <= pwdata[sar_pkg::DIM_BITS-1:0];
        sar_pkg::REG_DIM_1: cfg.dim_size[1] <= pwdata[sar_pkg::DIM_BITS-1:0];
        sar_pkg::REG_DIM_2: cfg.dim_size[2] <= pwdata[sar_pkg::DIM_BITS-1:0];
        sar_pkg::REG_DIM_3: cfg.dim_size[3] <= pwdata[sar_pkg::DIM_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  // Read back the addressed register, zero-extended
  always_comb begin
    case (reg_idx)
      sar_pkg::REG_RANK:  prdata = sar_pkg::DATA_BITS'(cfg.rank);
      sar_pkg::REG_AXIS:  prdata = sar_pkg::DATA_BITS'(cfg.reduce_axis);
      sar_pkg::REG_DIM_0: prdata = sar_pkg::DATA_BITS'(cfg.dim_size[0]);
      sar_pkg::REG_DIM_1: prdata = sar_pkg::DATA_BITS'(cfg.dim_size[1]);
      sar_pkg::REG_DIM_2: prdata = sar_pkg::DATA_BITS'(cfg.dim_size[2]);
      sar_pkg::REG_DIM_3: prdata = sar_pkg::DATA_BITS'(cfg.dim_size[3]);
      default:            prdata = '0;
    endcase
  end

  // Sequence each request: load, linearize if accumulating, read, modify, write back
  sar_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Hold the accumulator memory and the result register
  sar_datapath #(
    .OUT_DEPTH  (OUT_DEPTH),
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .cmd           (cmd),
    .stat          (stat),
    .func          (func),
    .coord_0       (coord_0),
    .coord_1       (coord_1),
    .coord_2       (coord_2),
    .coord_3       (coord_3),
    .nonzero_value (nonzero_value),
    .read_index    (read_index),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .entry_value   (entry_value),
    .linear_index  (linear_index),
    .status        (status)
  );

endmodule

[rtl/sar_ctrl.sv]
// Controller state machine: clear pass, linearize steps, read, modify and write.
module sar_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  sar_pkg::sar_stat_t   stat,
  output sar_pkg::sar_cmd_t    cmd
);

  sar_pkg::sar_state_t state;
  sar_pkg::sar_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sar_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    case (state)
      sar_pkg::ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (stat.clear_done) begin
          state_next = sar_pkg::ST_IDLE;
        end
      end
      sar_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = stat.new_accum ? sar_pkg::ST_LIN : sar_pkg::ST_ADDR;
        end
      end
      sar_pkg::ST_LIN: begin
        cmd.step = 1'b1;
        if (stat.step_last) begin
          state_next = sar_pkg::ST_ADDR;
        end
      end
      sar_pkg::ST_ADDR: begin
        cmd.addr   = 1'b1;
        state_next = sar_pkg::ST_RMW;
      end
      sar_pkg::ST_RMW: begin
        // hold until the output register can take the result
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_next = sar_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = sar_pkg::ST_CLEAR;
      end
    endcase
  end

endmodule

[rtl/sar_datapath.sv]
// Datapath: coordinate linearizer, accumulator memory, saturating adder, output register.
module sar_datapath #(
  parameter int OUT_DEPTH  = sar_pkg::DEF_OUT_DEPTH,
  parameter int VALUE_BITS = sar_pkg::DEF_VALUE_BITS
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  sar_pkg::sar_cfg_t                         cfg,
  input  sar_pkg::sar_cmd_t                         cmd,
  output sar_pkg::sar_stat_t                        stat,
  input  logic [sar_pkg::FUNC_BITS-1:0]             func,
  input  logic [sar_pkg::COORD_BITS-1:0]            coord_0,
  input  logic [sar_pkg::COORD_BITS-1:0]            coord_1,
  input  logic [sar_pkg::COORD_BITS-1:0]            coord_2,
  input  logic [sar_pkg::COORD_BITS-1:0]            coord_3,
  input  logic signed [sar_pkg::IN_VALUE_BITS-1:0]  nonzero_value,
  input  logic [sar_pkg::INDEX_BITS-1:0]            read_index,
  output logic                                      out_valid,
  input  logic                                      out_stall,
  output logic signed [sar_pkg::IN_VALUE_BITS-1:0]  entry_value,
  output logic [sar_pkg::INDEX_BITS-1:0]            linear_index,
  output logic [sar_pkg::STATUS_BITS-1:0]           status
);

  localparam int IDX_BITS = $clog2(OUT_DEPTH);
  localparam int LW       = IDX_BITS + 1;
  localparam int PW       = sar_pkg::COORD_BITS + LW;
  localparam int SPW      = sar_pkg::DIM_BITS + LW;
  localparam int RW       = sar_pkg::INDEX_BITS + LW;
  localparam int SW       = ((VALUE_BITS > sar_pkg::IN_VALUE_BITS) ?
                             VALUE_BITS : sar_pkg::IN_VALUE_BITS) + 1;
  localparam logic signed [SW-1:0] SAT_HI =
    {{(SW-VALUE_BITS+1){1'b0}}, {(VALUE_BITS-1){1'b1}}};
  localparam logic signed [SW-1:0] SAT_LO = ~SAT_HI;
  localparam logic [LW-1:0] DEPTH_L = LW'(OUT_DEPTH);

  // Held request
  logic [sar_pkg::FUNC_BITS-1:0]                        func_q;
  logic [sar_pkg::NUM_COORDS-1:0][sar_pkg::COORD_BITS-1:0] coord_q;
  logic signed [sar_pkg::IN_VALUE_BITS-1:0]             value_q;
  logic [sar_pkg::INDEX_BITS-1:0]                       ri_q;

  // Linearizer
  logic [sar_pkg::STEP_BITS-1:0] step_cnt;
  logic [LW-1:0]                 lin;
  logic [LW-1:0]                 stride;
  logic                          bad;

  logic [sar_pkg::COORD_BITS-1:0] cur_c;
  logic [sar_pkg::DIM_BITS-1:0]   cur_d;
  logic                           active;
  logic [PW-1:0]                  term;
  logic [PW:0]                    lsum;
  logic [SPW-1:0]                 sprod;
  logic                           rank_ok;

  // Memory access
  logic signed [VALUE_BITS-1:0] mem [OUT_DEPTH];
  logic signed [VALUE_BITS-1:0] rdata;
  logic [IDX_BITS-1:0]          addr_q;
  logic [IDX_BITS-1:0]          rd_addr;
  logic [sar_pkg::STATUS_BITS-1:0] st_q;
  logic [sar_pkg::STATUS_BITS-1:0] st_calc;
  logic [IDX_BITS-1:0]          clr_cnt;
  logic [IDX_BITS+sar_pkg::COORD_BITS-1:0] ri_wide;
  logic [IDX_BITS+sar_pkg::INDEX_BITS-1:0] li_wide;

  logic                         is_accum;
  logic signed [SW-1:0]         sum_w;
  logic signed [SW-1:0]         sum_c;
  logic signed [VALUE_BITS-1:0] sum_v;
  logic signed [VALUE_BITS-1:0] res_v;
  logic signed [VALUE_BITS+sar_pkg::IN_VALUE_BITS-1:0] res_wide;
  logic                         we;
  logic signed [VALUE_BITS-1:0] wdata;

  assign is_accum = (func_q == sar_pkg::FUNC_ACCUM);
  assign rank_ok  = (cfg.rank != '0) && (32'(cfg.rank) <= sar_pkg::MAX_RANK) &&
                    (32'(cfg.rank) <= sar_pkg::NUM_COORDS) &&
                    ({1'b0, cfg.reduce_axis} < cfg.rank);

  assign stat.new_accum  = (func == sar_pkg::FUNC_ACCUM);
  assign stat.step_last  = (step_cnt == '0);
  assign stat.clear_done = (clr_cnt == IDX_BITS'(OUT_DEPTH - 1));
  assign stat.out_free   = !out_valid || !out_stall;

  // One dimension per step, from the last one down
  always_comb begin
    cur_c  = coord_q[step_cnt];
    cur_d  = cfg.dim_size[step_cnt];
    active = ({1'b0, step_cnt} < cfg.rank) && (step_cnt != cfg.reduce_axis);
    term   = PW'(cur_c) * PW'(stride);
    lsum   = (PW+1)'(lin) + (PW+1)'(term);
    sprod  = SPW'(stride) * SPW'(cur_d);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_q   <= func;
      coord_q  <= {coord_3, coord_2, coord_1, coord_0};
      value_q  <= nonzero_value;
      ri_q     <= read_index;
      step_cnt <= sar_pkg::STEP_BITS'(sar_pkg::NUM_COORDS - 1);
      lin      <= '0;
      stride   <= LW'(1);
      bad      <= !rank_ok;
    end else if (cmd.step) begin
      step_cnt <= step_cnt - 1'b1;
      if (active) begin
        if ({1'b0, cur_c} >= cur_d) begin
          bad <= 1'b1;
        end
        // clamp at the depth: anything that large is beyond the store anyway
        lin    <= (lsum >= (PW+1)'(OUT_DEPTH)) ? DEPTH_L : lsum[LW-1:0];
        stride <= (sprod >= SPW'(OUT_DEPTH)) ? DEPTH_L : sprod[LW-1:0];
      end
    end
  end

  always_comb begin
    ri_wide = (IDX_BITS+sar_pkg::COORD_BITS)'(ri_q);
    if (is_accum) begin
      rd_addr = lin[IDX_BITS-1:0];
      if (bad) begin
        st_calc = sar_pkg::STATUS_BAD;
      end else if (lin >= DEPTH_L) begin
        st_calc = sar_pkg::STATUS_BEYOND;
      end else begin
        st_calc = sar_pkg::STATUS_OK;
      end
    end else begin
      rd_addr = ri_wide[IDX_BITS-1:0];
      st_calc = (RW'(ri_q) >= RW'(OUT_DEPTH)) ? sar_pkg::STATUS_BEYOND
                                              : sar_pkg::STATUS_OK;
    end
  end

  // Saturating add and write-back selection
  always_comb begin
    sum_w = SW'(rdata) + SW'(value_q);
    if (sum_w > SAT_HI) begin
      sum_c = SAT_HI;
    end else if (sum_w < SAT_LO) begin
      sum_c = SAT_LO;
    end else begin
      sum_c = sum_w;
    end
    sum_v    = VALUE_BITS'(sum_c);
    res_v    = is_accum ? sum_v : rdata;
    res_wide = (VALUE_BITS+sar_pkg::IN_VALUE_BITS)'(res_v);
    li_wide  = (IDX_BITS+sar_pkg::INDEX_BITS)'(addr_q);
    we       = cmd.commit && (st_q == sar_pkg::STATUS_OK) &&
               (is_accum || (func_q == sar_pkg::FUNC_READ_ZERO));
    wdata    = is_accum ? sum_v : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clear && !stat.clear_done) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      mem[clr_cnt] <= '0;
    end else if (we) begin
      mem[addr_q] <= wdata;
    end
    if (cmd.addr) begin
      rdata  <= mem[rd_addr];
      addr_q <= rd_addr;
      st_q   <= st_calc;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      status <= st_q;
      if (st_q == sar_pkg::STATUS_OK) begin
        entry_value  <= res_wide[sar_pkg::IN_VALUE_BITS-1:0];
        linear_index <= li_wide[sar_pkg::INDEX_BITS-1:0];
      end else begin
        entry_value  <= '0;
        linear_index <= '0;
      end
    end
  end

endmodule

[sim/testbench.sv]
// Self-checking testbench for the sparse axis reduce accumulator top level.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // Extra codes the block must tolerate: the unused item kind and an unmapped register.
  localparam logic [sar_pkg::FUNC_BITS-1:0] FUNC_SPARE = 2'd3;
  localparam logic [2:0]                    REG_SPARE  = 3'd6;

  localparam logic signed [sar_pkg::IN_VALUE_BITS-1:0] Q_MAX = 32'sh7fff_ffff;
  localparam logic signed [sar_pkg::IN_VALUE_BITS-1:0] Q_MIN = 32'sh8000_0000;

  // Extra wait once the last result is back, before the shape is reprogrammed.
  localparam int SETTLE_CYCLES = 16;
  localparam int CYCLE_LIMIT   = 300000;

  typedef struct packed {
    logic [sar_pkg::FUNC_BITS-1:0]                           func;
    logic [sar_pkg::NUM_COORDS-1:0][sar_pkg::COORD_BITS-1:0] coord;
    logic signed [sar_pkg::IN_VALUE_BITS-1:0]                value;
    logic [sar_pkg::INDEX_BITS-1:0]                          read_index;
  } sum_req_t;

  typedef struct packed {
    logic signed [sar_pkg::IN_VALUE_BITS-1:0] entry_value;
    logic [sar_pkg::INDEX_BITS-1:0]           linear_index;
    logic [sar_pkg::STATUS_BITS-1:0]          status;
  } sum_result_t;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_BEAT} stall_mode_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                            psel    = 1'b0;
  logic                            penable = 1'b0;
  logic                            pwrite  = 1'b0;
  logic [sar_pkg::ADDR_BITS-1:0]   paddr   = '0;
  logic [sar_pkg::DATA_BITS-1:0]   pwdata  = '0;
  logic [sar_pkg::DATA_BITS-1:0]   prdata;
  logic                            pready;

  logic                                     in_valid      = 1'b0;
  logic                                     in_stall;
  logic [sar_pkg::FUNC_BITS-1:0]            func          = '0;
  logic [sar_pkg::COORD_BITS-1:0]           coord_0       = '0;
  logic [sar_pkg::COORD_BITS-1:0]           coord_1       = '0;
  logic [sar_pkg::COORD_BITS-1:0]           coord_2       = '0;
  logic [sar_pkg::COORD_BITS-1:0]           coord_3       = '0;
  logic signed [sar_pkg::IN_VALUE_BITS-1:0] nonzero_value = '0;
  logic [sar_pkg::INDEX_BITS-1:0]           read_index    = '0;

  logic                                     out_valid;
  logic                                     out_stall     = 1'b0;
  logic signed [sar_pkg::IN_VALUE_BITS-1:0] entry_value;
  logic [sar_pkg::INDEX_BITS-1:0]           linear_index;
  logic [sar_pkg::STATUS_BITS-1:0]          status;

  sparse_axis_reduce_accumulator_top u_top (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .func         (func),
    .coord_0      (coord_0),
    .coord_1      (coord_1),
    .coord_2      (coord_2),
    .coord_3      (coord_3),
    .nonzero_value(nonzero_value),
    .read_index   (read_index),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .entry_value  (entry_value),
    .linear_index (linear_index),
    .status       (status)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Shadow of the block: its registers and the accumulator memory.
  logic [sar_pkg::RANK_BITS-1:0] shape_rank;
  logic [sar_pkg::AXIS_BITS-1:0] shape_axis;
  logic [sar_pkg::DIM_BITS-1:0]  shape_dim [sar_pkg::NUM_COORDS];
  longint                        sum_store [sar_pkg::DEF_OUT_DEPTH];

  sum_req_t    pending_reqs[$];      // requests waiting for the driver
  sum_result_t expected_sums[$];     // predicted results, oldest first
  logic [sar_pkg::INDEX_BITS-1:0] hot_index[$]; // recently targeted entries, for reads

  bit          req_taken = 1'b0;
  int          mismatch_count = 0;
  int          cycle_count = 0;
  int          burst_left = 1;
  int          gap_left = 0;
  stall_mode_t stall_mode = STALL_NONE;
  int          stall_span = 0;

  // Row-major index over the configured shape, skipping the reduction axis.
  // Returns 0 when the rank, the axis or a coordinate is out of range.
  function automatic bit flatten_coords(
      input logic [sar_pkg::NUM_COORDS-1:0][sar_pkg::COORD_BITS-1:0] c,
      output longint lin);
    longint stride;
    bit     ok;
    int     j;
    lin = 0;
    stride = 1;
    ok = 1'b1;
    if (shape_rank < 1 || shape_rank > sar_pkg::MAX_RANK ||
        shape_rank > sar_pkg::NUM_COORDS || shape_axis >= shape_rank)
      return 1'b0;
    for (j = sar_pkg::NUM_COORDS - 1; j >= 0; j--) begin
      if (j < int'(shape_rank) && j != int'(shape_axis)) begin
        if (c[j] >= shape_dim[j]) begin
          ok = 1'b0;
        end else begin
          lin += longint'(c[j]) * stride;
          stride *= longint'(shape_dim[j]);
        end
      end
    end
    return ok;
  endfunction

  // Advance the shadow by one request and give the result it must produce.
  function automatic sum_result_t predict_sum(input sum_req_t r);
    sum_result_t res;
    longint      lin;
    longint      acc;
    longint      hi;
    longint      lo;
    logic signed [sar_pkg::IN_VALUE_BITS-1:0] addend;
    res = '0;
    hi = (longint'(1) << (sar_pkg::DEF_VALUE_BITS - 1)) - 1;
    lo = -hi - 1;
    if (r.func == sar_pkg::FUNC_ACCUM) begin
      addend = r.value;
      if (!flatten_coords(r.coord, lin)) begin
        res.status = sar_pkg::STATUS_BAD;
      end else if (lin >= sar_pkg::DEF_OUT_DEPTH) begin
        res.status = sar_pkg::STATUS_BEYOND;
      end else begin
        acc = sum_store[lin] + addend;
        if (acc > hi) acc = hi;
        if (acc < lo) acc = lo;
        sum_store[lin] = acc;
        res.entry_value  = acc[sar_pkg::IN_VALUE_BITS-1:0];
        res.linear_index = lin[sar_pkg::INDEX_BITS-1:0];
        res.status       = sar_pkg::STATUS_OK;
      end
    end else begin
      // Plain read, read-and-zero, and the unused kind acting as a plain read.
      if (r.read_index >= sar_pkg::DEF_OUT_DEPTH) begin
        res.status = sar_pkg::STATUS_BEYOND;
      end else begin
        res.entry_value  = sum_store[r.read_index][sar_pkg::IN_VALUE_BITS-1:0];
        res.linear_index = r.read_index;
        res.status       = sar_pkg::STATUS_OK;
        if (r.func == sar_pkg::FUNC_READ_ZERO) sum_store[r.read_index] = 0;
      end
    end
    return res;
  endfunction

  function automatic sum_req_t accum_req(input int c0, input int c1, input int c2,
                                         input int c3, input logic signed [31:0] v);
    sum_req_t r;
    r.func       = sar_pkg::FUNC_ACCUM;
    r.coord      = {c3[sar_pkg::COORD_BITS-1:0], c2[sar_pkg::COORD_BITS-1:0],
                    c1[sar_pkg::COORD_BITS-1:0], c0[sar_pkg::COORD_BITS-1:0]};
    r.value      = v;
    r.read_index = sar_pkg::INDEX_BITS'($urandom);
    return r;
  endfunction

  function automatic sum_req_t read_req(input logic [sar_pkg::FUNC_BITS-1:0] f,
                                        input int idx);
    sum_req_t r;
    r.func       = f;
    r.coord      = (sar_pkg::NUM_COORDS*sar_pkg::COORD_BITS)'({$urandom, $urandom});
    r.value      = $urandom;
    r.read_index = idx[sar_pkg::INDEX_BITS-1:0];
    return r;
  endfunction

  // Random request shaped by the current shape: mostly in-range nonzeros,
  // often on a few hot entries so sums build up and saturate.
  function automatic sum_req_t random_req();
    sum_req_t r;
    int       pick;
    int       j;
    int       top;
    longint   lin;
    r.func       = sar_pkg::FUNC_BITS'($urandom);
    r.coord      = (sar_pkg::NUM_COORDS*sar_pkg::COORD_BITS)'({$urandom, $urandom});
    r.value      = $urandom;
    r.read_index = sar_pkg::INDEX_BITS'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 65 || pick >= 96) begin
      r.func = sar_pkg::FUNC_ACCUM;
      if (pick < 65) begin
        for (j = 0; j < sar_pkg::NUM_COORDS; j++) begin
          top = (shape_dim[j] > 4096) ? 4095 : int'(shape_dim[j]) - 1;
          if (top >= 0 && $urandom_range(0, 9) != 0) begin
            if ($urandom_range(0, 1) == 0 && top > 2) top = 2;
            r.coord[j] = sar_pkg::COORD_BITS'($urandom_range(0, top));
          end
        end
      end
      case ($urandom_range(0, 5))
        0:       r.value = Q_MAX;
        1:       r.value = Q_MIN;
        2:       r.value = $urandom_range(0, 131071) - 65536;
        default: r.value = $urandom;
      endcase
      if (flatten_coords(r.coord, lin) && lin < sar_pkg::DEF_OUT_DEPTH) begin
        hot_index.push_back(lin[sar_pkg::INDEX_BITS-1:0]);
        if (hot_index.size() > 8) void'(hot_index.pop_front());
      end
    end else begin
      if (pick < 80)      r.func = sar_pkg::FUNC_READ;
      else if (pick < 92) r.func = sar_pkg::FUNC_READ_ZERO;
      else                r.func = FUNC_SPARE;
      if (hot_index.size() != 0 && $urandom_range(0, 9) < 7)
        r.read_index = hot_index[$urandom_range(0, hot_index.size() - 1)];
    end
    return r;
  endfunction

  // Register write: setup phase, then access phase; the shadow follows at once.
  task automatic write_reg(input logic [2:0] idx,
                           input logic [sar_pkg::DATA_BITS-1:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      sar_pkg::REG_RANK:  shape_rank   = data[sar_pkg::RANK_BITS-1:0];
      sar_pkg::REG_AXIS:  shape_axis   = data[sar_pkg::AXIS_BITS-1:0];
      sar_pkg::REG_DIM_0: shape_dim[0] = data[sar_pkg::DIM_BITS-1:0];
      sar_pkg::REG_DIM_1: shape_dim[1] = data[sar_pkg::DIM_BITS-1:0];
      sar_pkg::REG_DIM_2: shape_dim[2] = data[sar_pkg::DIM_BITS-1:0];
      sar_pkg::REG_DIM_3: shape_dim[3] = data[sar_pkg::DIM_BITS-1:0];
      default: ;
    endcase
  endtask

  // Hold until every request is sent and every result is back, then let the pipe settle.
  task automatic wait_drained();
    while (pending_reqs.size() != 0 || in_valid || expected_sums.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Reprogram the whole shape while idle, then queue a batch of random requests.
  task automatic run_shape(input int rk, input int ax, input int d0, input int d1,
                           input int d2, input int d3, input int count);
    int n;
    wait_drained();
    write_reg(sar_pkg::REG_RANK,  rk);
    write_reg(sar_pkg::REG_AXIS,  ax);
    write_reg(sar_pkg::REG_DIM_0, d0);
    write_reg(sar_pkg::REG_DIM_1, d1);
    write_reg(sar_pkg::REG_DIM_2, d2);
    write_reg(sar_pkg::REG_DIM_3, d3);
    hot_index.delete();
    for (n = 0; n < count; n++) pending_reqs.push_back(random_req());
  endtask

  initial begin
    shape_rank = 3'd2;
    shape_axis = 2'd0;
    foreach (shape_dim[j]) shape_dim[j] = 13'd1;
    foreach (sum_store[j]) sum_store[j] = 0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed requests on the reset shape: rank 2, axis 0, every extent 1,
    // so only coord_1 matters and entry 0 is the one live entry.
    pending_reqs.push_back(accum_req(0, 0, 0, 0, Q_MAX));
    pending_reqs.push_back(accum_req(0, 0, 0, 0, 32'sd1));            // clamp high
    pending_reqs.push_back(accum_req(4095, 0, 4095, 4095, Q_MIN));    // ignored coords
    pending_reqs.push_back(accum_req(0, 0, 0, 0, Q_MIN));             // clamp low
    pending_reqs.push_back(read_req(sar_pkg::FUNC_READ, 0));
    pending_reqs.push_back(read_req(sar_pkg::FUNC_READ_ZERO, 0));
    pending_reqs.push_back(read_req(FUNC_SPARE, 0));                   // reads the zero
    pending_reqs.push_back(accum_req(0, 1, 0, 0, 32'sd5));            // coordinate too big
    pending_reqs.push_back(accum_req(0, 4095, 0, 0, 32'sd5));
    pending_reqs.push_back(read_req(sar_pkg::FUNC_READ, 4095));        // cleared by reset
    pending_reqs.push_back(accum_req(0, 0, 0, 0, 32'sd0));
    pending_reqs.push_back(read_req(sar_pkg::FUNC_READ_ZERO, 4095));
    pending_reqs.push_back(accum_req(0, 0, 0, 0, 32'sh0001_0000));

    wait_drained();
    write_reg(REG_SPARE, $urandom);   // unmapped, must change nothing

    run_shape(1, 0, 7, 7, 7, 7, 90);              // rank 1: every nonzero lands on entry 0
    run_shape(2, 1, 4096, 1, 1, 1, 120);          // full index range through coord_0
    run_shape(3, 2, 64, 64, 4, 1, 120);
    run_shape(4, 3, 16, 16, 16, 5, 120);
    run_shape(4, 1, 8, 8191, 32, 32, 100);        // half the indexes beyond the store
    run_shape(3, 0, 0, 4096, 4096, 8191, 80);     // zero extent on the reduced axis
    run_shape(2, 0, 4096, 0, 1, 1, 50);           // zero extent rejects everything
    run_shape(4, 0, 1, 1, 1, 1, 50);
    run_shape(4, 2, 4096, 1, 8191, 1, 50);
    run_shape(2, 2, 64, 64, 64, 64, 40);          // axis not below rank
    run_shape(4, 3, 5, 7, 3, 4096, 40);           // axis 3 leaves the widest extent out
    run_shape(0, 0, 16, 16, 16, 16, 30);          // rank zero
    run_shape(5, 1, 16, 16, 16, 16, 30);          // rank above the maximum
    run_shape(7, 3, 8191, 8191, 8191, 8191, 30);
    run_shape(3, 1, 16, 8, 16, 1, 80);

    wait_drained();
    if (mismatch_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  // Request driver: bursts of random length with random gaps; a request
  // holds steady until the block takes it.
  always @(negedge clk) begin
    sum_req_t next_req;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !req_taken) begin
      // hold the stalled request
    end else if (gap_left != 0) begin
      gap_left <= gap_left - 1;
      in_valid <= 1'b0;
    end else if (pending_reqs.size() != 0) begin
      next_req = pending_reqs.pop_front();
      func          <= next_req.func;
      coord_0       <= next_req.coord[0];
      coord_1       <= next_req.coord[1];
      coord_2       <= next_req.coord[2];
      coord_3       <= next_req.coord[3];
      nonzero_value <= next_req.value;
      read_index    <= next_req.read_index;
      in_valid      <= 1'b1;
      if (burst_left <= 1) begin
        burst_left <= $urandom_range(1, 16);
        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      end else begin
        burst_left <= burst_left - 1;
      end
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Result stall: switch among a few patterns, each for a random span,
  // including spans with no stall at all.
  always @(negedge clk) begin
    if (stall_span == 0) begin
      stall_mode <= stall_mode_t'($urandom_range(0, 3));
      stall_span <= $urandom_range(16, 96);
    end else begin
      stall_span <= stall_span - 1;
    end
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
      default:     out_stall <= (stall_span % 4) < 2;
    endcase
  end

  // Monitor: predict on every accepted request, check every accepted result.
  always @(posedge clk) begin
    sum_result_t want;
    req_taken = !rst && in_valid && !in_stall;
    if (req_taken)
      expected_sums.push_back(predict_sum({func, coord_3, coord_2, coord_1, coord_0,
                                           nonzero_value, read_index}));
    if (!rst && out_valid && !out_stall) begin
      if (expected_sums.size() == 0) begin
        $display("%0t: unexpected result entry_value %h linear_index %h status %h",
                 $realtime, entry_value, linear_index, status);
        mismatch_count++;
      end else begin
        want = expected_sums.pop_front();
        if (entry_value !== want.entry_value) begin
          $display("%0t: entry_value expected %h actual %h",
                   $realtime, want.entry_value, entry_value);
          mismatch_count++;
        end
        if (linear_index !== want.linear_index) begin
          $display("%0t: linear_index expected %h actual %h",
                   $realtime, want.linear_index, linear_index);
          mismatch_count++;
        end
        if (status !== want.status) begin
          $display("%0t: status expected %h actual %h", $realtime, want.status, status);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: end the run as failed once the cycle count reaches the limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

endmodule
